### rtl/core/tspq_pkg.sv
// ----------------------------------------------------------------------------
// tspq_pkg: shared types and constants
// Sizes, status codes, register indexes and the configuration struct of the
// slot-gated strict-priority command queue.
// ----------------------------------------------------------------------------
package tspq_pkg;

  localparam int LEVELS         = 5;
  localparam int LEVEL_DEPTH    = 256;   // power of two: ring positions wrap by truncation
  localparam int DOWNLINK_FIRST = 30;
  localparam int DOWNLINK_END   = 34;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int POS_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int STORE_DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int ENTRY_W = 44;
  localparam int SEQ_W  = 32;
  localparam int DROP_W = 32;

  localparam int QLIMIT_W = 9;
  localparam int SLOTCFG_W = 5;
  localparam int SLOT_W = 6;

  localparam logic [SLOTCFG_W-1:0] UPLINK_COUNT_RST = SLOTCFG_W'(30);
  localparam logic [QLIMIT_W-1:0]  QUEUE_LIMIT_RST  = QLIMIT_W'(200);

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_OWN_UPLINK   = 3'd1,
    REG_BASE_STATION = 3'd2,
    REG_UPLINK_COUNT = 3'd3,
    REG_QUEUE_LIMIT  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_REFUSED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_SENT    = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  typedef struct packed {
    logic                 enable;
    logic [SLOTCFG_W-1:0] own_uplink_slot;
    logic                 is_base_station;
    logic [SLOTCFG_W-1:0] uplink_slot_count;
    logic [QLIMIT_W-1:0]  queue_limit;
  } cfg_t;

endpackage

### rtl/core/tspq_ram.sv
// ----------------------------------------------------------------------------
// tspq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while re is low.
// ----------------------------------------------------------------------------
module tspq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/tspq_cfg_regs.sv
// ----------------------------------------------------------------------------
// tspq_cfg_regs: configuration register file
// APB-style write and read-back of the five control registers.
// ----------------------------------------------------------------------------
module tspq_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tspq_pkg::CFG_AW-1:0] paddr,
  input  logic [tspq_pkg::CFG_DW-1:0] pwdata,
  output logic [tspq_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output tspq_pkg::cfg_t            cfg
);
  import tspq_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable            <= 1'b0;
      cfg.own_uplink_slot   <= '0;
      cfg.is_base_station   <= 1'b0;
      cfg.uplink_slot_count <= UPLINK_COUNT_RST;
      cfg.queue_limit       <= QUEUE_LIMIT_RST;
    end else if (wr) begin
      case (idx)
        REG_ENABLE:       cfg.enable            <= pwdata[0];
        REG_OWN_UPLINK:   cfg.own_uplink_slot   <= pwdata[SLOTCFG_W-1:0];
        REG_BASE_STATION: cfg.is_base_station   <= pwdata[0];
        REG_UPLINK_COUNT: cfg.uplink_slot_count <= pwdata[SLOTCFG_W-1:0];
        REG_QUEUE_LIMIT:  cfg.queue_limit       <= pwdata[QLIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_ENABLE:       prdata = CFG_DW'(cfg.enable);
      REG_OWN_UPLINK:   prdata = CFG_DW'(cfg.own_uplink_slot);
      REG_BASE_STATION: prdata = CFG_DW'(cfg.is_base_station);
      REG_UPLINK_COUNT: prdata = CFG_DW'(cfg.uplink_slot_count);
      REG_QUEUE_LIMIT:  prdata = CFG_DW'(cfg.queue_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/core/tdma_slot_priority_command_queue.sv
// ----------------------------------------------------------------------------
// tdma_slot_priority_command_queue: slot-gated strict-priority command queue
// Enqueues commands into five priority levels (level 0 as a stack, the rest
// as FIFOs) and sends the head of the lowest-numbered nonempty level in owned slots.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     s_tuser action, s_tdata command/slot
//  m_*       out        m_tvalid / m_tready     m_tuser status, s_tdata-like header
//  cfg       in         psel & penable & pwrite pwdata to register paddr/4
//
//  One request per cycle sustained while m_tready is high; each request
//  yields one result, passing the input register, then the result register
//  (its header fields come from the entry store's registered read port).
//  Reset clears the levels, counters and sequence number; the store itself
//  is not cleared, since only written entries are ever read.
//  A stalled result holds the pipe; the input side keeps accepting while
//  the input register is empty or moves on.
//
module tdma_slot_priority_command_queue (
  input  logic        clk,
  input  logic        rst,
  // streaming input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // cmd_type[3:0] priority_req[6:4] target_id[14:7]
                                // payload_tag[30:15] slot_index[36:31] zero[39:37]
  input  logic        s_tuser,  // action[0]
  // streaming output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // seq_high[15:0] type_priority_byte[23:16]
                                // out_target[31:24] out_payload_tag[47:32]
                                // drop_count[79:48]
  output logic [2:0]  m_tuser,  // status[2:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tspq_pkg::*;

  cfg_t cfg;

  tspq_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // input register
  logic             in_valid;
  logic             in_action;
  logic [3:0]       in_type;
  logic [2:0]       in_prio;
  logic [7:0]       in_target;
  logic [15:0]      in_tag;
  logic [SLOT_W-1:0] in_slot;

  // result register
  logic              res_valid;
  status_t           res_status;
  logic [LVL_W-1:0]  res_level;
  logic [DROP_W-1:0] res_drop;

  // level state
  logic [POS_W-1:0]  level_head    [LEVELS];
  logic [CNT_W-1:0]  level_count   [LEVELS];
  logic [DROP_W-1:0] drop_counters [LEVELS];
  logic [SEQ_W-1:0]  sequence_counter;

  logic res_adv, in_adv;

  assign res_adv  = !res_valid || m_tready;
  assign in_adv   = in_valid && res_adv;
  assign s_tready = !in_valid || res_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_type   <= s_tdata[3:0];
      in_prio   <= s_tdata[6:4];
      in_target <= s_tdata[14:7];
      in_tag    <= s_tdata[30:15];
      in_slot   <= s_tdata[36:31];
    end
  end

  // decision logic
  logic [LVL_W-1:0]  req_lvl;
  logic [LVL_W-1:0]  sel_lvl;
  logic              any_ready;
  logic [LVL_W-1:0]  idx;
  logic [POS_W-1:0]  head_idx;
  logic [CNT_W-1:0]  count_idx;
  logic [DROP_W-1:0] drop_idx;
  logic [CNT_W-1:0]  cap;
  logic              full;
  logic              slot_send;
  logic              is_enq;
  logic              do_store, do_drop, do_send;
  logic [SEQ_W-1:0]  seq_inc;
  logic [DROP_W-1:0] drop_inc;
  logic [POS_W-1:0]  wpos;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  status_t           status_next;
  logic [DROP_W-1:0] drop_next;

  always_comb begin
    if (32'(in_prio) > LEVELS - 1) begin
      req_lvl = LVL_W'(LEVELS - 1);
    end else begin
      req_lvl = LVL_W'(in_prio);
    end
  end

  // lowest-numbered nonempty level
  always_comb begin
    sel_lvl   = '0;
    any_ready = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (level_count[i] != '0) begin
        sel_lvl   = LVL_W'(i);
        any_ready = 1'b1;
      end
    end
  end

  assign is_enq    = !in_action;
  assign idx       = is_enq ? req_lvl : sel_lvl;
  assign head_idx  = level_head[idx];
  assign count_idx = level_count[idx];
  assign drop_idx  = drop_counters[idx];

  always_comb begin
    if (idx == '0 || 32'(cfg.queue_limit) > LEVEL_DEPTH) begin
      cap = CNT_W'(LEVEL_DEPTH);
    end else begin
      cap = CNT_W'(cfg.queue_limit);
    end
  end
  assign full = count_idx >= cap;

  always_comb begin
    slot_send = 1'b0;
    if (in_slot < SLOT_W'(cfg.uplink_slot_count)) begin
      slot_send = in_slot == SLOT_W'(cfg.own_uplink_slot);
    end else if (in_slot >= SLOT_W'(DOWNLINK_FIRST) && in_slot < SLOT_W'(DOWNLINK_END)) begin
      slot_send = cfg.is_base_station;
    end
  end

  assign do_store = is_enq && cfg.enable && !full;
  assign do_drop  = is_enq && cfg.enable && full;
  assign do_send  = !is_enq && cfg.enable && slot_send && any_ready;

  assign seq_inc  = sequence_counter + SEQ_W'(1);
  assign drop_inc = (drop_idx == '1) ? drop_idx : drop_idx + DROP_W'(1);

  // level 0 pushes in front of its head, the others append behind the tail
  assign wpos  = (idx == '0) ? head_idx - POS_W'(1) : head_idx + count_idx[POS_W-1:0];
  assign waddr = ADDR_W'(idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(wpos);
  assign raddr = ADDR_W'(idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head_idx);
  assign wdata = {seq_inc[SEQ_W-1:16], in_type, in_target, in_tag};

  always_comb begin
    drop_next = drop_idx;
    if (is_enq) begin
      if (!cfg.enable) begin
        status_next = ST_REFUSED;
      end else if (full) begin
        status_next = ST_DROPPED;
        drop_next   = drop_inc;
      end else begin
        status_next = ST_QUEUED;
      end
    end else if (do_send) begin
      status_next = ST_SENT;
    end else begin
      status_next = ST_NONE;
      drop_next   = '0;
    end
  end

  tspq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (in_adv && do_store),
    .waddr(waddr),
    .wdata(wdata),
    .re   (in_adv && do_send),
    .raddr(raddr),
    .rdata(rdata)
  );

  // level state update
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        level_head[i]    <= '0;
        level_count[i]   <= '0;
        drop_counters[i] <= '0;
      end
    end else if (in_adv) begin
      if (is_enq && cfg.enable) begin
        sequence_counter <= seq_inc;
      end
      if (do_drop) begin
        drop_counters[idx] <= drop_inc;
      end
      if (do_store) begin
        level_count[idx] <= count_idx + CNT_W'(1);
        if (idx == '0) begin
          level_head[idx] <= wpos;
        end
      end
      if (do_send) begin
        level_count[idx] <= count_idx - CNT_W'(1);
        level_head[idx]  <= head_idx + POS_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_adv) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      res_status <= status_next;
      res_level  <= idx;
      res_drop   <= drop_next;
    end
  end

  logic        sent;
  logic [15:0] out_seq_high;
  logic [7:0]  out_type_prio;
  logic [7:0]  out_target;
  logic [15:0] out_payload_tag;

  assign sent            = res_status == ST_SENT;
  assign out_seq_high    = sent ? rdata[43:28] : '0;
  assign out_type_prio   = sent ? {4'(res_level), rdata[27:24]} : '0;
  assign out_target      = sent ? rdata[23:16] : '0;
  assign out_payload_tag = sent ? rdata[15:0] : '0;

  assign m_tvalid = res_valid;
  assign m_tuser  = res_status;
  assign m_tdata  = {res_drop, out_payload_tag, out_target, out_type_prio, out_seq_high};

endmodule
